// ===== src/wfp_pkg.sv =====
// wfp_pkg: shared types and constants for the websocket frame parser
// no dependencies; imported by every module of the parser but wfp_in_stage
`timescale 1ns / 1ps

package wfp_pkg;

  // status codes on the result channel
  localparam logic [1:0] STATUS_CONT = 2'd0;
  localparam logic [1:0] STATUS_DONE = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  // control opcodes (close, ping, pong)
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length escapes for extended length fields
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // byte counts of the header fields
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // one result beat
  typedef struct packed {
    logic [1:0]  status;
    logic        header_done;
    logic        final_flag;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic [63:0] frame_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        was_unmasked;
    logic [7:0]  mask_byte;
  } wfp_res_t;

  function automatic logic is_control(input logic [3:0] op);
    is_control = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

// ===== src/wfp_in_stage.sv =====
// wfp_in_stage: input register for incoming stream bytes
// depends on nothing but the clock; stall comes from the downstream advance
`timescale 1ns / 1ps

module wfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       advance,
  output logic       full,
  output logic [7:0] byte_q
);

  // hold while a byte is parked and the parser cannot take it
  assign in_stall = full && !advance;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  // byte register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= data_byte;
    end
  end

endmodule

// ===== src/wfp_parse.sv =====
// wfp_parse: frame header/payload state machine, one byte per step
// depends on wfp_pkg; result goes combinationally to the output stage
`timescale 1ns / 1ps

module wfp_parse
  import wfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  output wfp_res_t   res
);

  typedef enum logic [2:0] {
    ST_FIRST  = 3'd0,
    ST_SECOND = 3'd1,
    ST_LEN16  = 3'd2,
    ST_LEN64  = 3'd3,
    ST_MASK   = 3'd4,
    ST_CTRL   = 3'd5,
    ST_DATA   = 3'd6
  } stage_t;

  stage_t      stage, stage_next;
  logic [3:0]  field_cnt, field_cnt_next;
  logic        fin_bit, fin_bit_next;
  logic [2:0]  rsv_bits, rsv_bits_next;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic [63:0] length_reg, length_reg_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] payload_count, payload_count_next;

  logic [3:0]  cnt_inc;
  logic [63:0] len_base;
  logic [63:0] count_inc;
  logic [7:0]  key_sel;

  assign cnt_inc   = field_cnt + 4'd1;
  assign count_inc = payload_count + 64'd1;
  assign len_base  = (field_cnt == 4'd0) ? 64'd0 : length_reg;

  // key byte for this payload position, first key byte at offset zero
  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_sel = mask_key[31:24];
      2'd1:    key_sel = mask_key[23:16];
      2'd2:    key_sel = mask_key[15:8];
      default: key_sel = mask_key[7:0];
    endcase
  end

  // next state and result for the byte being consumed
  always_comb begin
    stage_next         = stage;
    field_cnt_next     = field_cnt;
    fin_bit_next       = fin_bit;
    rsv_bits_next      = rsv_bits;
    opcode_reg_next    = opcode_reg;
    length_reg_next    = length_reg;
    mask_key_next      = mask_key;
    payload_count_next = payload_count;
    res                = '0;
    res.status         = STATUS_CONT;

    case (stage)
      ST_SECOND: begin
        length_reg_next = {57'd0, data_byte[6:0]};
        field_cnt_next  = 4'd0;
        if (!data_byte[7]) begin
          res.status = STATUS_BAD;
          stage_next = ST_FIRST;
        end else if (data_byte[6:0] == LEN_EXT16) begin
          stage_next = ST_LEN16;
        end else if (data_byte[6:0] == LEN_EXT64) begin
          stage_next = ST_LEN64;
        end else begin
          stage_next = ST_MASK;
        end
      end
      ST_LEN16, ST_LEN64: begin
        if (is_control(opcode_reg)) begin
          res.status = STATUS_BAD;
          stage_next = ST_FIRST;
        end else begin
          length_reg_next = {len_base[55:0], data_byte};
          field_cnt_next  = cnt_inc;
          if (cnt_inc >= ((stage == ST_LEN16) ? EXT16_BYTES : EXT64_BYTES)) begin
            field_cnt_next = 4'd0;
            stage_next     = ST_MASK;
          end
        end
      end
      ST_MASK: begin
        mask_key_next  = {mask_key[23:0], data_byte};
        field_cnt_next = cnt_inc;
        if (cnt_inc >= KEY_BYTES) begin
          field_cnt_next     = 4'd0;
          res.header_done    = 1'b1;
          payload_count_next = 64'd0;
          if (length_reg == 64'd0) begin
            res.status = STATUS_DONE;
            stage_next = ST_FIRST;
          end else begin
            stage_next = is_control(opcode_reg) ? ST_CTRL : ST_DATA;
          end
        end
      end
      ST_CTRL, ST_DATA: begin
        res.payload_valid = 1'b1;
        res.mask_byte     = key_sel;
        if (stage == ST_CTRL) begin
          res.payload_byte = data_byte ^ key_sel;
          res.was_unmasked = 1'b1;
        end else begin
          res.payload_byte = data_byte;
        end
        payload_count_next = count_inc;
        if (count_inc == length_reg) begin
          res.status = STATUS_DONE;
          stage_next = ST_FIRST;
        end
      end
      default: begin
        // first header byte, also any unused stage code
        fin_bit_next    = data_byte[7];
        rsv_bits_next   = data_byte[6:4];
        opcode_reg_next = data_byte[3:0];
        length_reg_next = 64'd0;
        field_cnt_next  = 4'd0;
        stage_next      = ST_SECOND;
      end
    endcase

    res.final_flag    = fin_bit_next;
    res.reserved_bits = rsv_bits_next;
    res.frame_opcode  = opcode_reg_next;
    res.frame_length  = length_reg_next;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ST_FIRST;
      field_cnt     <= 4'd0;
      fin_bit       <= 1'b0;
      rsv_bits      <= 3'd0;
      opcode_reg    <= 4'd0;
      length_reg    <= 64'd0;
      mask_key      <= 32'd0;
      payload_count <= 64'd0;
    end else if (step) begin
      stage         <= stage_next;
      field_cnt     <= field_cnt_next;
      fin_bit       <= fin_bit_next;
      rsv_bits      <= rsv_bits_next;
      opcode_reg    <= opcode_reg_next;
      length_reg    <= length_reg_next;
      mask_key      <= mask_key_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

// ===== src/wfp_out_stage.sv =====
// wfp_out_stage: result register driving the output channel
// depends on wfp_pkg for the result beat type
`timescale 1ns / 1ps

module wfp_out_stage
  import wfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  wfp_res_t res_in,
  output logic     advance,
  output logic     out_valid,
  input  logic     out_stall,
  output wfp_res_t res_q
);

  // register can load when empty or being drained this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (advance && take) begin
      res_q <= res_in;
    end
  end

endmodule

// ===== src/websocket_frame_parser_core.sv =====
// websocket_frame_parser_core: top level of the websocket frame parser
// depends on wfp_pkg, wfp_in_stage, wfp_parse, wfp_out_stage
//
//   channel | handshake            | payload
//   input   | in_valid / in_stall  | data_byte
//   output  | out_valid / out_stall| status .. mask_byte
//
// one byte per clock sustained while out_stall lets the result register drain;
// an accepted byte loads into the input register, and the parser steps it into
// the result register, where its result beat is offered.
// the rate is set by the parser state registers, which update once per byte.
// rst is synchronous and clears the stage, counters and both valid flags.
// out_stall holds the result register and, through it, the input register.
`timescale 1ns / 1ps

module websocket_frame_parser_core
  import wfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        header_done,
  output logic        final_flag,
  output logic [2:0]  reserved_bits,
  output logic [3:0]  frame_opcode,
  output logic [63:0] frame_length,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic        was_unmasked,
  output logic [7:0]  mask_byte
);

  logic       advance;
  logic       full;
  logic [7:0] byte_q;
  wfp_res_t   res_next;
  wfp_res_t   res_q;

  wfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .data_byte(data_byte),
    .advance  (advance),
    .full     (full),
    .byte_q   (byte_q)
  );

  wfp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (full && advance),
    .data_byte(byte_q),
    .res      (res_next)
  );

  wfp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (full),
    .res_in   (res_next),
    .advance  (advance),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_q    (res_q)
  );

  // result fields
  assign status        = res_q.status;
  assign header_done   = res_q.header_done;
  assign final_flag    = res_q.final_flag;
  assign reserved_bits = res_q.reserved_bits;
  assign frame_opcode  = res_q.frame_opcode;
  assign frame_length  = res_q.frame_length;
  assign payload_valid = res_q.payload_valid;
  assign payload_byte  = res_q.payload_byte;
  assign was_unmasked  = res_q.was_unmasked;
  assign mask_byte     = res_q.mask_byte;

endmodule

// ===== src/wfp_checker.sv =====
// wfp_checker: port-level assertions for the websocket frame parser
// depends on wfp_pkg; bound to websocket_frame_parser_core
`timescale 1ns / 1ps

module wfp_checker
  import wfp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic       header_done,
  input logic       payload_valid,
  input logic [7:0] payload_byte,
  input logic       was_unmasked,
  input logic [7:0] mask_byte
);

  // non-payload beats carry zero payload and key bytes
  a_idle_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !payload_valid) |-> (payload_byte == 8'd0 && mask_byte == 8'd0))
    else $error("payload fields set on a non-payload beat");

  // unmasking only happens on payload beats
  a_unmask_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_unmasked) |-> payload_valid)
    else $error("was_unmasked without payload");

  // header completion and payload are never the same beat
  a_hdr_not_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && header_done) |-> !payload_valid)
    else $error("header_done on a payload beat");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_CONT || status == STATUS_DONE || status == STATUS_BAD))
    else $error("undefined status code");

  // a stalled result beat stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(payload_byte)))
    else $error("result changed under stall");

endmodule

bind websocket_frame_parser_core wfp_checker u_wfp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .header_done  (header_done),
  .payload_valid(payload_valid),
  .payload_byte (payload_byte),
  .was_unmasked (was_unmasked),
  .mask_byte    (mask_byte)
);

// ===== tb/wfp_frame_checker.sv =====
// wfp_frame_checker: watches both channels of the websocket frame parser,
// predicts every result beat from the accepted input bytes and compares them
// depends on wfp_pkg for the result struct, status codes and opcodes
`timescale 1ns / 1ps

module wfp_frame_checker
  import wfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic        header_done,
  input  logic        final_flag,
  input  logic [2:0]  reserved_bits,
  input  logic [3:0]  frame_opcode,
  input  logic [63:0] frame_length,
  input  logic        payload_valid,
  input  logic [7:0]  payload_byte,
  input  logic        was_unmasked,
  input  logic [7:0]  mask_byte,
  output int          fail_count,
  output int          waiting,
  output int          frames_done,
  output int          frames_bad,
  output int          payload_beats
);

  // where the parser stands inside a frame
  typedef enum logic [2:0] {
    AWAIT_FIRST,
    AWAIT_SECOND,
    EXT_LEN16,
    EXT_LEN64,
    MASK_KEY,
    CTRL_PAYLOAD,
    DATA_PAYLOAD
  } parse_stage_t;

  parse_stage_t pstage;
  logic [3:0]   hdr_cnt;
  logic         fin_q;
  logic [2:0]   rsv_q;
  logic [3:0]   opcode_q;
  logic [63:0]  length_q;
  logic [31:0]  key_q;
  logic [63:0]  payload_idx;

  wfp_res_t expected_q[$];

  // advance the frame decoder by one byte and return the beat it should produce
  function automatic wfp_res_t parse_byte(input logic [7:0] b);
    wfp_res_t r;
    r = '0;
    case (pstage)
      AWAIT_SECOND: begin
        length_q = {57'd0, b[6:0]};
        hdr_cnt = '0;
        if (!b[7]) begin
          r.status = STATUS_BAD;
          pstage = AWAIT_FIRST;
        end else if (b[6:0] == LEN_EXT16) begin
          pstage = EXT_LEN16;
        end else if (b[6:0] == LEN_EXT64) begin
          pstage = EXT_LEN64;
        end else begin
          pstage = MASK_KEY;
        end
      end
      EXT_LEN16, EXT_LEN64: begin
        // control frames may not carry an extended length
        if (opcode_q inside {OP_CLOSE, OP_PING, OP_PONG}) begin
          r.status = STATUS_BAD;
          pstage = AWAIT_FIRST;
        end else begin
          if (hdr_cnt == 4'd0) length_q = '0;
          length_q = {length_q[55:0], b};
          hdr_cnt = hdr_cnt + 4'd1;
          if (hdr_cnt >= ((pstage == EXT_LEN16) ? EXT16_BYTES : EXT64_BYTES)) begin
            hdr_cnt = '0;
            pstage = MASK_KEY;
          end
        end
      end
      MASK_KEY: begin
        key_q = {key_q[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= KEY_BYTES) begin
          hdr_cnt = '0;
          r.header_done = 1'b1;
          payload_idx = '0;
          if (length_q == 64'd0) begin
            r.status = STATUS_DONE;
            pstage = AWAIT_FIRST;
          end else if (opcode_q inside {OP_CLOSE, OP_PING, OP_PONG}) begin
            pstage = CTRL_PAYLOAD;
          end else begin
            pstage = DATA_PAYLOAD;
          end
        end
      end
      CTRL_PAYLOAD, DATA_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.mask_byte = 8'(key_q >> (8 * (3 - int'(payload_idx[1:0]))));
        if (pstage == CTRL_PAYLOAD) begin
          r.payload_byte = b ^ r.mask_byte;
          r.was_unmasked = 1'b1;
        end else begin
          r.payload_byte = b;
        end
        payload_idx = payload_idx + 64'd1;
        if (payload_idx == length_q) begin
          r.status = STATUS_DONE;
          pstage = AWAIT_FIRST;
        end
      end
      default: begin
        fin_q = b[7];
        rsv_q = b[6:4];
        opcode_q = b[3:0];
        length_q = '0;
        hdr_cnt = '0;
        pstage = AWAIT_SECOND;
      end
    endcase
    r.final_flag = fin_q;
    r.reserved_bits = rsv_q;
    r.frame_opcode = opcode_q;
    r.frame_length = length_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want_v);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want_v);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want_v);
    if (got !== want_v) report_mismatch(what, got, want_v);
  endtask

  // predict on accepted input beats, compare on accepted output beats
  always @(posedge clk) begin
    wfp_res_t want;
    if (rst) begin
      pstage = AWAIT_FIRST;
      hdr_cnt = '0;
      fin_q = 1'b0;
      rsv_q = '0;
      opcode_q = '0;
      length_q = '0;
      key_q = '0;
      payload_idx = '0;
      expected_q.delete();
      fail_count = 0;
      frames_done = 0;
      frames_bad = 0;
      payload_beats = 0;
      waiting <= 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(parse_byte(data_byte));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", {62'd0, status}, 64'd0);
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(status), 64'(want.status));
          check_field("header_done", 64'(header_done), 64'(want.header_done));
          check_field("final_flag", 64'(final_flag), 64'(want.final_flag));
          check_field("reserved_bits", 64'(reserved_bits), 64'(want.reserved_bits));
          check_field("frame_opcode", 64'(frame_opcode), 64'(want.frame_opcode));
          check_field("frame_length", frame_length, want.frame_length);
          check_field("payload_valid", 64'(payload_valid), 64'(want.payload_valid));
          check_field("payload_byte", 64'(payload_byte), 64'(want.payload_byte));
          check_field("was_unmasked", 64'(was_unmasked), 64'(want.was_unmasked));
          check_field("mask_byte", 64'(mask_byte), 64'(want.mask_byte));
          if (want.status == STATUS_DONE) frames_done++;
          if (want.status == STATUS_BAD) frames_bad++;
          if (want.payload_valid) payload_beats++;
        end
      end
      waiting <= expected_q.size();
    end
  end

endmodule

// ===== tb/websocket_frame_parser_core_tb.sv =====
// websocket_frame_parser_core_tb: drives byte streams of websocket frames into
// the parser and gives the verdict; depends on wfp_pkg, websocket_frame_parser_core
// and wfp_frame_checker, which predicts and compares every result beat
`timescale 1ns / 1ps

module websocket_frame_parser_core_tb;
  import wfp_pkg::*;

  // length encodings of the second header byte
  localparam int unsigned FORM_SHORT = 0;
  localparam int unsigned FORM_EXT16 = 1;
  localparam int unsigned FORM_EXT64 = 2;

  localparam int STREAM_BEATS = 1700;
  localparam int QUIET_FROM   = 1450;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        header_done;
  logic        final_flag;
  logic [2:0]  reserved_bits;
  logic [3:0]  frame_opcode;
  logic [63:0] frame_length;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        was_unmasked;
  logic [7:0]  mask_byte;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int sent_beats = 0;
  int quiet_cycles = 0;
  int fails;
  int waiting;
  int frames_done;
  int frames_bad;
  int payload_beats;

  websocket_frame_parser_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .header_done(header_done), .final_flag(final_flag),
    .reserved_bits(reserved_bits), .frame_opcode(frame_opcode),
    .frame_length(frame_length), .payload_valid(payload_valid),
    .payload_byte(payload_byte), .was_unmasked(was_unmasked), .mask_byte(mask_byte)
  );

  wfp_frame_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .header_done(header_done), .final_flag(final_flag),
    .reserved_bits(reserved_bits), .frame_opcode(frame_opcode),
    .frame_length(frame_length), .payload_valid(payload_valid),
    .payload_byte(payload_byte), .was_unmasked(was_unmasked), .mask_byte(mask_byte),
    .fail_count(fails), .waiting(waiting), .frames_done(frames_done),
    .frames_bad(frames_bad), .payload_beats(payload_beats)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on cycles where no beat moves on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one input beat, with an occasional idle burst in front of it
  task automatic send_beat(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_beats++;
    if (sent_beats == HOLD_AT) hold_req = 1'b1;
  endtask

  // one frame; rejected frames stop at the byte that draws the rejection,
  // and at most cap payload bytes are sent
  task automatic send_frame(input logic [7:0] hdr0, input logic masked,
                            input int unsigned form, input logic [63:0] plen,
                            input logic [63:0] cap);
    logic [7:0]  bytes[$];
    logic [31:0] key;
    logic [63:0] n;
    key = $urandom;
    bytes.push_back(hdr0);
    case (form)
      FORM_EXT16: bytes.push_back({masked, LEN_EXT16});
      FORM_EXT64: bytes.push_back({masked, LEN_EXT64});
      default:    bytes.push_back({masked, plen[6:0]});
    endcase
    if (masked && form != FORM_SHORT && hdr0[3:0] inside {OP_CLOSE, OP_PING, OP_PONG}) begin
      bytes.push_back(8'($urandom));
    end else if (masked) begin
      if (form == FORM_EXT16) begin
        bytes.push_back(plen[15:8]);
        bytes.push_back(plen[7:0]);
      end else if (form == FORM_EXT64) begin
        for (int i = 7; i >= 0; i--) bytes.push_back(plen[8*i +: 8]);
      end
      for (int i = 3; i >= 0; i--) bytes.push_back(key[8*i +: 8]);
      n = (plen > cap) ? cap : plen;
      for (longint unsigned i = 0; i < n; i++) bytes.push_back(8'($urandom));
    end
    foreach (bytes[i]) send_beat(bytes[i]);
  endtask

  // result side: random stall bursts, plus one long hold to back the block up
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned kind;
    int unsigned form;
    logic [7:0]  hdr0;
    logic [63:0] plen;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: masked ping, empty close, unmasked text, control with
    // extended length, fragment with rsv bits and a 16-bit length
    send_frame(8'h89, 1'b1, FORM_SHORT, 64'd2, 64'd2);
    send_frame(8'h88, 1'b1, FORM_SHORT, 64'd0, 64'd0);
    send_frame(8'h81, 1'b0, FORM_SHORT, 64'd5, 64'd0);
    send_frame(8'h8A, 1'b1, FORM_EXT16, 64'd0, 64'd0);
    send_frame(8'h72, 1'b1, FORM_EXT16, 64'd3, 64'd3);

    // random frames, mostly well formed
    while (sent_beats < STREAM_BEATS) begin
      if (sent_beats >= QUIET_FROM) idle_on = 1'b0;
      kind = $urandom_range(0, 99);
      hdr0 = 8'($urandom);
      if (kind < 8) begin
        send_frame(hdr0, 1'b0, $urandom_range(0, 2), 64'($urandom_range(0, 125)), 64'd0);
      end else if (kind < 14) begin
        hdr0[3:0] = 4'(OP_CLOSE + $urandom_range(0, 2));
        send_frame(hdr0, 1'b1, FORM_EXT16 + $urandom_range(0, 1), 64'd0, 64'd0);
      end else begin
        if (kind < 50) hdr0[3:0] = 4'(OP_CLOSE + $urandom_range(0, 2));
        form = $urandom_range(0, 9);
        form = (form < 7 || hdr0[3:0] inside {OP_CLOSE, OP_PING, OP_PONG}) ? FORM_SHORT :
               (form == 7) ? FORM_EXT16 : FORM_EXT64;
        if (form == FORM_SHORT)
          plen = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(13, 125)) :
                                               64'($urandom_range(0, 12));
        else
          plen = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 300)) :
                                               64'($urandom_range(0, 40));
        send_frame(hdr0, 1'b1, form, plen, plen);
      end
    end

    // largest 64-bit length last: the frame never completes
    idle_on = 1'b0;
    send_frame(8'h82, 1'b1, FORM_EXT64, '1, 64'd6);
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d input beats: %0d frames completed, %0d rejected, %0d payload beats",
             sent_beats, frames_done, frames_bad, payload_beats);
    if (fails == 0 && waiting == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== websocket_frame_parser_core.f =====
src/wfp_pkg.sv
src/wfp_in_stage.sv
src/wfp_parse.sv
src/wfp_out_stage.sv
src/websocket_frame_parser_core.sv
src/wfp_checker.sv
tb/wfp_frame_checker.sv
tb/websocket_frame_parser_core_tb.sv
